// ===== rtl/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants for the voxel ray traversal block
// Fixed-point formats, traversal job record and cross-product pair tables.
// ----------------------------------------------------------------------------
package vrt_pkg;

	localparam int FRAC_BITS = 11;
	localparam int INT_BITS  = 5;

	localparam int IN_W     = 16;                    // width of one coordinate field
	localparam int COORD_W  = INT_BITS + FRAC_BITS;  // significant coordinate bits
	localparam int CELL_W   = 7;                     // cell index, two's complement
	localparam int FACE_W   = 3;
	localparam int CNT_W    = 7;                     // step count / cap
	localparam int NUM_W    = FRAC_BITS + 7;         // holds (cap + 1) units
	localparam int PROD_W   = NUM_W + COORD_W;       // numerator * delta
	localparam int SUM_W    = INT_BITS + 2;          // sum of three integer spans
	localparam int CMP_W    = (SUM_W > CNT_W) ? SUM_W : CNT_W;
	localparam int N_PAIRS  = 6;
	localparam int PAIR_W   = 3;
	localparam int Q_DEPTH  = 2;
	localparam int QPTR_W   = 1;

	localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(64);
	localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(1);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// cross-product slots: P[row][col] = numerator[row] * delta[col]
	localparam logic [PAIR_W-1:0] P_XY = 3'd0;
	localparam logic [PAIR_W-1:0] P_YX = 3'd1;
	localparam logic [PAIR_W-1:0] P_XZ = 3'd2;
	localparam logic [PAIR_W-1:0] P_ZX = 3'd3;
	localparam logic [PAIR_W-1:0] P_YZ = 3'd4;
	localparam logic [PAIR_W-1:0] P_ZY = 3'd5;

	typedef struct packed {
		logic [2:0][CELL_W-1:0]    cidx;
		logic [2:0]                dir;    // 1: stepping toward lower index
		logic [2:0]                dz;     // zero delta, axis never chosen
		logic [2:0][COORD_W-1:0]   delta;
		logic [N_PAIRS-1:0][PROD_W-1:0] prod;
		logic [CNT_W-1:0]          count;
	} job_t;

	function automatic logic [1:0] pair_row(input logic [PAIR_W-1:0] k);
		logic [1:0] r;
		case (k)
			P_XY, P_XZ: r = AXIS_X;
			P_YX, P_YZ: r = AXIS_Y;
			default:    r = AXIS_Z;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_col(input logic [PAIR_W-1:0] k);
		logic [1:0] c;
		case (k)
			P_YX, P_ZX: c = AXIS_X;
			P_XY, P_ZY: c = AXIS_Y;
			default:    c = AXIS_Z;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/vrt_if.sv =====
// ----------------------------------------------------------------------------
// vrt_if: valid/ready channel interfaces
// Ray segment input channel and traversed cell output channel.
// ----------------------------------------------------------------------------
interface vrt_ray_if;
	import vrt_pkg::*;
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] start_x;
	logic [IN_W-1:0] start_y;
	logic [IN_W-1:0] start_z;
	logic [IN_W-1:0] end_x;
	logic [IN_W-1:0] end_y;
	logic [IN_W-1:0] end_z;

	modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		input ready);
	modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
		output ready);
endinterface

interface vrt_cell_if;
	import vrt_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [CELL_W-1:0] cell_x;
	logic signed [CELL_W-1:0] cell_y;
	logic signed [CELL_W-1:0] cell_z;
	logic [FACE_W-1:0]        face;
	logic                     last;

	modport source (output valid, cell_x, cell_y, cell_z, face, last, input ready);
	modport sink (input valid, cell_x, cell_y, cell_z, face, last, output ready);
endinterface

// ===== rtl/voxel_ray_traversal_top.sv =====
// Flow: a ray is accepted, setup forms the six products with one multiplier and
//   then pushes the job to the queue; the stepper pops it and emits its cells.
// Output: N = min(sum of integer spans, cap) cells per ray, one per cycle while
//   cells.ready allows; a new ray is taken only after the last job is pushed.
//   A ray with no crossings is accepted and produces nothing.
// Reset: arst_n clears all control state asynchronously; max_steps returns to 64.
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top: 3-D voxel ray traversal
// Front end sets up each ray, a two-entry queue decouples it from the
// stepper that emits the entered cells with face code and last flag.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top import vrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	vrt_ray_if.sink          rays,
	vrt_cell_if.source       cells
);

	// cap register; the user must write it only while the block is idle (not enforced)
	logic [CNT_W-1:0] max_steps_q;

	// front -> queue
	job_t front_job;
	logic push, full;

	// queue -> back
	job_t back_job;
	logic avail, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_steps_q <= CAP_LIMIT;
		else if (cfg_we)
			max_steps_q <= cfg_wdata;
	end

	// setup: per-axis delta, direction, start numerator, cell, count, and
	// the six cross products num[a] * delta[b] through one multiplier
	vrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_steps (max_steps_q),
		.rays      (rays),
		.job       (front_job),
		.push      (push),
		.full      (full)
	);

	// lets setup of the next ray run while the current one is traversed
	vrt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (front_job),
		.push   (push),
		.full   (full),
		.rd_job (back_job),
		.avail  (avail),
		.pop    (pop)
	);

	// stepper: compares cross products (no divide), ties go to the higher axis (y over x, z over both),
	// results held in an output register so stepping continues under ready
	vrt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (back_job),
		.avail  (avail),
		.pop    (pop),
		.cells  (cells)
	);

endmodule

// ===== rtl/vrt_front.sv =====
// ----------------------------------------------------------------------------
// vrt_front: ray setup
// Accepts a ray, derives per-axis delta, direction, numerator, start cell and
// step count, then forms the six cross products with one shared multiplier.
// ----------------------------------------------------------------------------
module vrt_front import vrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] max_steps,
	vrt_ray_if.sink          rays,
	output job_t             job,
	output logic             push,
	input  logic             full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MUL  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t           state_q;
	logic [PAIR_W-1:0] k_q;
	job_t              job_q;
	logic [2:0][NUM_W-1:0] num_q;

	logic [2:0][COORD_W-1:0] s, e, delta_d;
	logic [2:0][NUM_W-1:0]   num_d;
	logic [2:0][CELL_W-1:0]  cell_d;
	logic [2:0]              dir_d, dz_d;
	logic [2:0][INT_BITS-1:0] span;
	logic [SUM_W-1:0]        total;
	logic [CNT_W-1:0]        cap, count_d;
	logic                    accept;

	always_comb begin
		s[0] = COORD_W'(rays.start_x);
		s[1] = COORD_W'(rays.start_y);
		s[2] = COORD_W'(rays.start_z);
		e[0] = COORD_W'(rays.end_x);
		e[1] = COORD_W'(rays.end_y);
		e[2] = COORD_W'(rays.end_z);
		total = '0;
		for (int a = 0; a < 3; a++) begin
			logic [INT_BITS-1:0] is, ie;
			is = s[a][COORD_W-1 -: INT_BITS];
			ie = e[a][COORD_W-1 -: INT_BITS];
			dir_d[a]   = (e[a] < s[a]);
			delta_d[a] = dir_d[a] ? (s[a] - e[a]) : (e[a] - s[a]);
			dz_d[a]    = (delta_d[a] == '0);
			if (dz_d[a])
				num_d[a] = '0;
			else if (dir_d[a])
				num_d[a] = NUM_W'(s[a][FRAC_BITS-1:0]);
			else
				num_d[a] = NUM_W'(1 << FRAC_BITS) - NUM_W'(s[a][FRAC_BITS-1:0]);
			cell_d[a] = CELL_W'(is);
			span[a]   = (ie > is) ? (ie - is) : (is - ie);
			total     = total + SUM_W'(span[a]);
		end
		// cap clamped to 1..64
		if (max_steps < CAP_MIN)
			cap = CAP_MIN;
		else if (max_steps > CAP_LIMIT)
			cap = CAP_LIMIT;
		else
			cap = max_steps;
		count_d = (CMP_W'(total) < CMP_W'(cap)) ? CNT_W'(total) : cap;
	end

	assign rays.ready = (state_q == F_IDLE);
	assign accept     = rays.valid && rays.ready;
	assign push       = (state_q == F_PUSH) && !full;
	assign job        = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					// a ray with no crossings produces nothing
					if (accept && count_d != '0) begin
						state_q <= F_MUL;
						k_q     <= '0;
					end
				end
				F_MUL: begin
					if (k_q == PAIR_W'(N_PAIRS - 1))
						state_q <= F_PUSH;
					k_q <= k_q + 1'b1;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.cidx  <= cell_d;
			job_q.dir   <= dir_d;
			job_q.dz    <= dz_d;
			job_q.delta <= delta_d;
			job_q.count <= count_d;
			num_q       <= num_d;
		end
		if (state_q == F_MUL)
			job_q.prod[k_q] <= num_q[pair_row(k_q)] * job_q.delta[pair_col(k_q)];
	end

endmodule

// ===== rtl/vrt_queue.sv =====
// ----------------------------------------------------------------------------
// vrt_queue: job queue
// Two-entry register FIFO between ray setup and the traversal stepper.
// ----------------------------------------------------------------------------
module vrt_queue import vrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic push,
	output logic full,
	output job_t rd_job,
	output logic avail,
	input  logic pop
);

	job_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full   = (cnt_q == (QPTR_W+1)'(Q_DEPTH));
	assign avail  = (cnt_q != '0);
	assign rd_job = mem_q[rp_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= next_ptr(wp_q);
			if (pop)
				rp_q <= next_ptr(rp_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

endmodule

// ===== rtl/vrt_back.sv =====
// ----------------------------------------------------------------------------
// vrt_back: traversal stepper
// Picks the axis with the earliest crossing from the cross products, steps
// the cell, updates the products by shifted deltas, one cell per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module vrt_back import vrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t job,
	input  logic avail,
	output logic pop,
	vrt_cell_if.source cells
);

	job_t                 cur_q;
	logic                 busy_q;
	logic                 ovalid_q;
	logic [CELL_W-1:0]    ocx_q, ocy_q, ocz_q;
	logic [FACE_W-1:0]    oface_q;
	logic                 olast_q;

	logic                 adv, step;
	logic                 f_xy, f_xz, f_yz;
	logic [1:0]           ax;
	logic [2:0][CELL_W-1:0] cell_n;
	logic [N_PAIRS-1:0][PROD_W-1:0] prod_n;

	// t(a) < t(b) strictly; a zero-delta axis never wins
	function automatic logic first_of(input logic dza, input logic dzb,
		input logic [PROD_W-1:0] pab, input logic [PROD_W-1:0] pba);
		logic r;
		if (dza)
			r = 1'b0;
		else if (dzb)
			r = 1'b1;
		else
			r = (pab < pba);
		return r;
	endfunction

	assign adv  = !ovalid_q || cells.ready;
	assign step = busy_q && adv;
	assign pop  = !busy_q && avail;

	always_comb begin
		f_xy = first_of(cur_q.dz[AXIS_X], cur_q.dz[AXIS_Y], cur_q.prod[P_XY], cur_q.prod[P_YX]);
		f_xz = first_of(cur_q.dz[AXIS_X], cur_q.dz[AXIS_Z], cur_q.prod[P_XZ], cur_q.prod[P_ZX]);
		f_yz = first_of(cur_q.dz[AXIS_Y], cur_q.dz[AXIS_Z], cur_q.prod[P_YZ], cur_q.prod[P_ZY]);
		if (f_xy && f_xz)
			ax = AXIS_X;
		else if (f_yz)
			ax = AXIS_Y;
		else
			ax = AXIS_Z;

		cell_n = cur_q.cidx;
		cell_n[ax] = cur_q.dir[ax] ? (cur_q.cidx[ax] - 1'b1) : (cur_q.cidx[ax] + 1'b1);

		// numerator[ax] grows by one unit: its products grow by delta << FRAC_BITS
		for (int k = 0; k < N_PAIRS; k++) begin
			if (pair_row(PAIR_W'(k)) == ax)
				prod_n[k] = cur_q.prod[k] +
					(PROD_W'(cur_q.delta[pair_col(PAIR_W'(k))]) << FRAC_BITS);
			else
				prod_n[k] = cur_q.prod[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop)
				busy_q <= 1'b1;
			else if (step && cur_q.count == CNT_W'(1))
				busy_q <= 1'b0;
			if (step)
				ovalid_q <= 1'b1;
			else if (cells.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= job;
		else if (step) begin
			cur_q.cidx  <= cell_n;
			cur_q.prod  <= prod_n;
			cur_q.count <= cur_q.count - 1'b1;
		end
		if (step) begin
			ocx_q   <= cell_n[AXIS_X];
			ocy_q   <= cell_n[AXIS_Y];
			ocz_q   <= cell_n[AXIS_Z];
			oface_q <= {ax, cur_q.dir[ax]};
			olast_q <= (cur_q.count == CNT_W'(1));
		end
	end

	assign cells.valid  = ovalid_q;
	assign cells.cell_x = ocx_q;
	assign cells.cell_y = ocy_q;
	assign cells.cell_z = ocz_q;
	assign cells.face   = oface_q;
	assign cells.last   = olast_q;

endmodule
